// ----- hdl/fltp_pkg.sv -----
// shared types, frame layout offsets and helper functions for the payment parser
package fltp_pkg;

  // key length in bytes; the layout below follows from it
  localparam int KEY_BYTES = 32;

  localparam int OFF_W = 8;

  // frame layout, byte offsets
  localparam logic [OFF_W-1:0] SKIP_STOP     = 8'd36;
  localparam logic [OFF_W-1:0] SRC_TYPE_END  = 8'd39;
  localparam logic [OFF_W-1:0] SRC_KEY_START = 8'd40;
  localparam logic [OFF_W-1:0] SRC_KEY_STOP  = OFF_W'(40 + KEY_BYTES);
  localparam logic [OFF_W-1:0] FEE_END       = OFF_W'(40 + KEY_BYTES + 3);
  localparam logic [OFF_W-1:0] SEQ_START     = OFF_W'(40 + KEY_BYTES + 4);
  localparam logic [OFF_W-1:0] SEQ_STOP      = OFF_W'(40 + KEY_BYTES + 12);
  localparam logic [OFF_W-1:0] TIME_END      = OFF_W'(40 + KEY_BYTES + 15);
  localparam logic [OFF_W-1:0] MEMO_END      = OFF_W'(40 + KEY_BYTES + 19);
  localparam logic [OFF_W-1:0] COUNT_END     = OFF_W'(40 + KEY_BYTES + 23);
  localparam logic [OFF_W-1:0] OPSRC_END     = OFF_W'(40 + KEY_BYTES + 27);
  localparam logic [OFF_W-1:0] OPTYPE_END    = OFF_W'(40 + KEY_BYTES + 31);
  localparam logic [OFF_W-1:0] DST_TYPE_END  = OFF_W'(40 + KEY_BYTES + 35);
  localparam logic [OFF_W-1:0] DST_KEY_START = OFF_W'(40 + KEY_BYTES + 36);
  localparam logic [OFF_W-1:0] DST_KEY_STOP  = OFF_W'(40 + 2 * KEY_BYTES + 36);
  localparam logic [OFF_W-1:0] ASSET_END     = OFF_W'(40 + 2 * KEY_BYTES + 39);
  localparam logic [OFF_W-1:0] AMOUNT_START  = OFF_W'(40 + 2 * KEY_BYTES + 40);
  localparam logic [OFF_W-1:0] AMOUNT_END    = OFF_W'(40 + 2 * KEY_BYTES + 47);
  localparam logic [OFF_W-1:0] FRAME_BYTES   = OFF_W'(40 + 2 * KEY_BYTES + 48);

  // byte classification reported with each result
  typedef enum logic [2:0] {
    KIND_SKIP   = 3'd0,
    KIND_SRC    = 3'd1,
    KIND_DST    = 3'd2,
    KIND_FIELD  = 3'd3,
    KIND_ACCEPT = 3'd4,
    KIND_ERROR  = 3'd5,
    KIND_DROP   = 3'd6
  } kind_t;

  // one input word as held in the input register
  typedef struct packed {
    logic       frame_start;
    logic [7:0] byte_value;
  } in_word_t;

  // one result word
  typedef struct packed {
    kind_t       byte_kind;
    logic [7:0]  key_byte;
    logic [31:0] fee_value;
    logic [63:0] amount_value;
  } res_word_t;

  // true on the last byte of a word that must match a fixed value
  function automatic logic is_check_end(input logic [OFF_W-1:0] off);
    return (off == SRC_TYPE_END) || (off == TIME_END) || (off == MEMO_END) ||
           (off == COUNT_END) || (off == OPSRC_END) || (off == OPTYPE_END) ||
           (off == DST_TYPE_END) || (off == ASSET_END);
  endfunction

  // required value of the check word ending at off
  function automatic logic [31:0] check_want(input logic [OFF_W-1:0] off);
    return ((off == COUNT_END) || (off == OPTYPE_END)) ? 32'd1 : 32'd0;
  endfunction

endpackage

// ----- hdl/fltp_in_reg.sv -----
// input register stage for incoming transaction bytes
module fltp_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fltp_pkg::in_word_t in_word,
  output logic               held_valid,
  input  logic               advance,
  output fltp_pkg::in_word_t held_word
);

  // room when empty or when the held word moves on this cycle
  assign in_ready = !held_valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_word <= in_word;
    end
  end

endmodule

// ----- hdl/fltp_parse_core.sv -----
// parse state and per-byte classification, field capture and checks
module fltp_parse_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  fltp_pkg::in_word_t  in_word,
  output fltp_pkg::res_word_t res_word
);

  logic [fltp_pkg::OFF_W-1:0] byte_offset;
  logic [fltp_pkg::OFF_W-1:0] byte_offset_next;
  logic [31:0]                word_shift;
  logic [31:0]                word_shift_next;
  logic [31:0]                fee_hold;
  logic [31:0]                fee_hold_next;
  logic [63:0]                amount_hold;
  logic [63:0]                amount_hold_next;
  logic                       frame_failed;
  logic                       frame_failed_next;

  logic [fltp_pkg::OFF_W-1:0] off;
  logic [31:0]                ws_base;
  logic [31:0]                fee_base;
  logic [63:0]                amt_base;
  logic                       failed_base;
  logic [31:0]                ws_new;
  fltp_pkg::kind_t            kind;

  // next state and result for the held byte
  always_comb begin
    off         = in_word.frame_start ? '0    : byte_offset;
    ws_base     = in_word.frame_start ? '0    : word_shift;
    fee_base    = in_word.frame_start ? '0    : fee_hold;
    amt_base    = in_word.frame_start ? '0    : amount_hold;
    failed_base = in_word.frame_start ? 1'b0  : frame_failed;
    ws_new      = {ws_base[23:0], in_word.byte_value};

    byte_offset_next  = off;
    word_shift_next   = ws_base;
    fee_hold_next     = fee_base;
    amount_hold_next  = amt_base;
    frame_failed_next = failed_base;
    kind              = fltp_pkg::KIND_DROP;
    res_word.fee_value    = '0;
    res_word.amount_value = '0;

    if (!(failed_base || (off >= fltp_pkg::FRAME_BYTES))) begin
      word_shift_next  = ws_new;
      byte_offset_next = off + fltp_pkg::OFF_W'(1);

      // classify by position
      if ((off < fltp_pkg::SKIP_STOP) ||
          ((off >= fltp_pkg::SEQ_START) && (off < fltp_pkg::SEQ_STOP))) begin
        kind = fltp_pkg::KIND_SKIP;
      end else if ((off >= fltp_pkg::SRC_KEY_START) && (off < fltp_pkg::SRC_KEY_STOP)) begin
        kind = fltp_pkg::KIND_SRC;
      end else if ((off >= fltp_pkg::DST_KEY_START) && (off < fltp_pkg::DST_KEY_STOP)) begin
        kind = fltp_pkg::KIND_DST;
      end else begin
        kind = fltp_pkg::KIND_FIELD;
      end

      // field capture
      if (off == fltp_pkg::FEE_END) begin
        fee_hold_next = ws_new;
      end
      if (off >= fltp_pkg::AMOUNT_START) begin
        amount_hold_next = {amt_base[55:0], in_word.byte_value};
      end

      // fixed-value checks, then acceptance on the last amount byte
      if (fltp_pkg::is_check_end(off) && (ws_new != fltp_pkg::check_want(off))) begin
        kind              = fltp_pkg::KIND_ERROR;
        frame_failed_next = 1'b1;
      end else if (off == fltp_pkg::AMOUNT_END) begin
        kind                  = fltp_pkg::KIND_ACCEPT;
        res_word.fee_value    = fee_base;
        res_word.amount_value = amount_hold_next;
      end
    end

    res_word.byte_kind = kind;
    res_word.key_byte  = in_word.byte_value;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset  <= '0;
      word_shift   <= '0;
      fee_hold     <= '0;
      amount_hold  <= '0;
      frame_failed <= 1'b0;
    end else if (advance) begin
      byte_offset  <= byte_offset_next;
      word_shift   <= word_shift_next;
      fee_hold     <= fee_hold_next;
      amount_hold  <= amount_hold_next;
      frame_failed <= frame_failed_next;
    end
  end

  // an error latches the failed flag
  a_error_sets_failed: assert property (@(posedge clk) disable iff (rst)
    advance && (res_word.byte_kind == fltp_pkg::KIND_ERROR) |=> frame_failed)
    else $error("error byte did not mark the frame failed");

  // a failed frame drops bytes until the next frame start
  a_failed_drops: assert property (@(posedge clk) disable iff (rst)
    advance && frame_failed && !in_word.frame_start |->
      (res_word.byte_kind == fltp_pkg::KIND_DROP))
    else $error("byte of a failed frame not dropped");

  // offset never runs past the frame end
  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    byte_offset <= fltp_pkg::FRAME_BYTES)
    else $error("byte offset beyond frame length");

endmodule

// ----- hdl/fltp_out_reg.sv -----
// result register stage toward the downstream consumer
module fltp_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  fltp_pkg::res_word_t load_word,
  output logic                out_valid,
  input  logic                out_ready,
  output fltp_pkg::res_word_t out_word
);

  // valid flag: set on load, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= load_word;
    end
  end

endmodule

// ----- hdl/fixed_layout_payment_tx_parser_top.sv -----
// top level of the fixed-layout payment transaction parser
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata byte_value, tuser frame_start
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata key/fee/amount, tuser byte_kind
//
// one byte word accepted per cycle unless the result register stalls, one result word
// per byte, through the input register, then parse logic into the result register
// rst is synchronous; it clears both valid flags and the parse state to offset 0
// a stalled result register holds the parse; the input register still takes one
// more word, so the input keeps flowing until both stages are full
module fixed_layout_payment_tx_parser_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] byte_value
  input  logic         s_axis_tuser,   // [0] frame_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // [7:0] key_byte, [39:8] fee_value, [103:40] amount_value
  output logic [2:0]   m_axis_tuser    // [2:0] byte_kind
);

  fltp_pkg::in_word_t  in_word;
  fltp_pkg::in_word_t  held_word;
  fltp_pkg::res_word_t res_word;
  fltp_pkg::res_word_t out_word;
  logic                held_valid;
  logic                advance;

  assign in_word.frame_start = s_axis_tuser;
  assign in_word.byte_value  = s_axis_tdata;

  // held word moves into the result register when that has room
  assign advance = held_valid && (!m_axis_tvalid || m_axis_tready);

  fltp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_word    (in_word),
    .held_valid (held_valid),
    .advance    (advance),
    .held_word  (held_word)
  );

  fltp_parse_core u_parse_core (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_word  (held_word),
    .res_word (res_word)
  );

  fltp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .load_word (res_word),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word)
  );

  // pack the result word
  assign m_axis_tdata = {out_word.amount_value, out_word.fee_value, out_word.key_byte};
  assign m_axis_tuser = out_word.byte_kind;

  // fee and amount are zero on every word except the accepting one
  a_fields_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != fltp_pkg::KIND_ACCEPT) |->
      (m_axis_tdata[103:8] == '0))
    else $error("fee or amount driven on a non-accepting word");

endmodule

// ----- test/fixed_layout_payment_tx_parser_top_tb.sv -----
// self-checking testbench for the fixed-layout payment transaction parser
`timescale 1ns / 1ps

module fixed_layout_payment_tx_parser_top_tb;

  // frame layout, kept apart from the package so a layout slip there shows up
  localparam int KEY_LEN       = fltp_pkg::KEY_BYTES;
  localparam int SKIP_END      = 36;
  localparam int SRC_TYPE_LAST = 39;
  localparam int SRC_KEY_FIRST = 40;
  localparam int SRC_KEY_END   = 40 + KEY_LEN;
  localparam int FEE_LAST      = KEY_LEN + 43;
  localparam int SEQ_FIRST     = KEY_LEN + 44;
  localparam int SEQ_END       = KEY_LEN + 52;
  localparam int COUNT_LAST    = KEY_LEN + 63;
  localparam int OPTYPE_LAST   = KEY_LEN + 71;
  localparam int DST_KEY_FIRST = KEY_LEN + 76;
  localparam int DST_KEY_END   = 2 * KEY_LEN + 76;
  localparam int AMOUNT_FIRST  = 2 * KEY_LEN + 80;
  localparam int AMOUNT_LAST   = 2 * KEY_LEN + 87;
  localparam int FRAME_LEN     = 2 * KEY_LEN + 88;
  localparam int CHECK_WORDS   = 8;

  // run shape
  localparam int ITEM_TARGET  = 1450;
  localparam int CALM_TAIL    = 260;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  // last byte offset of each type or flag word that must hold a fixed value
  function automatic int check_end(input int idx);
    case (idx)
      0:       return SRC_TYPE_LAST;
      1:       return KEY_LEN + 55;
      2:       return KEY_LEN + 59;
      3:       return COUNT_LAST;
      4:       return KEY_LEN + 67;
      5:       return OPTYPE_LAST;
      6:       return KEY_LEN + 75;
      default: return 2 * KEY_LEN + 79;
    endcase
  endfunction

  // parse predictor plus the queue of result words still owed by the block
  class payment_parse_scoreboard;
    int                  offset;
    logic [31:0]         word_shift;
    logic [31:0]         fee_hold;
    logic [63:0]         amount_hold;
    bit                  failed;
    fltp_pkg::res_word_t expected_q[$];
    int unsigned         errors;
    int unsigned         results_seen;

    function new();
      offset       = 0;
      word_shift   = '0;
      fee_hold     = '0;
      amount_hold  = '0;
      failed       = 1'b0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // predict the result word for one accepted byte
    function void note_byte(input logic [7:0] value, input logic start);
      fltp_pkg::res_word_t r;
      bit        checked;
      logic [31:0] required;
      checked  = 1'b0;
      required = '0;
      if (start) begin
        offset      = 0;
        word_shift  = '0;
        fee_hold    = '0;
        amount_hold = '0;
        failed      = 1'b0;
      end
      r.key_byte     = value;
      r.fee_value    = '0;
      r.amount_value = '0;
      if (failed || offset >= FRAME_LEN) begin
        r.byte_kind = fltp_pkg::KIND_DROP;
      end else begin
        word_shift = {word_shift[23:0], value};
        if (offset < SKIP_END || (offset >= SEQ_FIRST && offset < SEQ_END))
          r.byte_kind = fltp_pkg::KIND_SKIP;
        else if (offset >= SRC_KEY_FIRST && offset < SRC_KEY_END)
          r.byte_kind = fltp_pkg::KIND_SRC;
        else if (offset >= DST_KEY_FIRST && offset < DST_KEY_END)
          r.byte_kind = fltp_pkg::KIND_DST;
        else
          r.byte_kind = fltp_pkg::KIND_FIELD;
        if (offset == FEE_LAST)
          fee_hold = word_shift;
        if (offset >= AMOUNT_FIRST)
          amount_hold = {amount_hold[55:0], value};
        for (int i = 0; i < CHECK_WORDS; i++) begin
          if (offset == check_end(i)) checked = 1'b1;
        end
        if (offset == COUNT_LAST || offset == OPTYPE_LAST) required = 32'd1;
        if (checked && word_shift != required) begin
          r.byte_kind = fltp_pkg::KIND_ERROR;
          failed      = 1'b1;
        end else if (offset == AMOUNT_LAST) begin
          r.byte_kind    = fltp_pkg::KIND_ACCEPT;
          r.fee_value    = fee_hold;
          r.amount_value = amount_hold;
        end
        offset++;
      end
      expected_q.push_back(r);
    endfunction

    task report_mismatch(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // compare one accepted result word with the oldest prediction
    task check_result(input logic [2:0] kind, input logic [103:0] data);
      fltp_pkg::res_word_t want;
      logic [7:0]  key;
      logic [31:0] fee;
      logic [63:0] amount;
      key    = data[7:0];
      fee    = data[39:8];
      amount = data[103:40];
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with no byte outstanding", results_seen));
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.byte_kind)
        report_mismatch($sformatf("result %0d kind %0d, want %s", results_seen, kind,
                                  want.byte_kind.name()));
      if (key !== want.key_byte)
        report_mismatch($sformatf("result %0d key_byte %h, want %h", results_seen, key,
                                  want.key_byte));
      if (fee !== want.fee_value)
        report_mismatch($sformatf("result %0d fee %h, want %h", results_seen, fee,
                                  want.fee_value));
      if (amount !== want.amount_value)
        report_mismatch($sformatf("result %0d amount %h, want %h", results_seen, amount,
                                  want.amount_value));
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_valid = 1'b0;
  logic          s_ready;
  logic [7:0]    s_data = '0;
  logic          s_user = 1'b0;
  logic          m_valid;
  logic          m_ready = 1'b0;
  logic [103:0]  m_data;
  logic [2:0]    m_user;

  payment_parse_scoreboard sb;
  logic [7:0]    frame_buf [FRAME_LEN];
  bit            calm = 1'b0;
  int unsigned   bytes_sent = 0;
  int unsigned   cycles = 0;

  fixed_layout_payment_tx_parser_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  always #4 clk = ~clk;

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("fixed_layout_payment_tx_parser_top regression: fail");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_valid && m_ready) sb.check_result(m_user, m_data);
  end

  // receiver backpressure in bursts, none once the run goes calm
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        m_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // fill frame_buf with a well-formed transaction around the given fee and amount
  function automatic void build_frame(input logic [31:0] fee, input logic [63:0] amount);
    int e;
    for (int i = 0; i < FRAME_LEN; i++) frame_buf[i] = 8'($urandom_range(0, 255));
    for (int w = 0; w < CHECK_WORDS; w++) begin
      e = check_end(w);
      for (int j = 0; j < 4; j++) frame_buf[e - j] = 8'h00;
    end
    frame_buf[COUNT_LAST]  = 8'h01;
    frame_buf[OPTYPE_LAST] = 8'h01;
    for (int j = 0; j < 4; j++) frame_buf[FEE_LAST - j] = fee[8*j +: 8];
    for (int j = 0; j < 8; j++) frame_buf[AMOUNT_LAST - j] = amount[8*j +: 8];
  endfunction

  // spoil one byte of a check word; returns the offset where the error lands
  function automatic int break_check_word(input int idx);
    int e;
    e = check_end(idx % CHECK_WORDS);
    frame_buf[e - $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    return e;
  endfunction

  // one input word; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] value, input logic start);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= value;
    s_user  <= start;
    do @(posedge clk); while (!s_ready);
    sb.note_byte(value, start);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int count, input logic start);
    for (int i = 0; i < count; i++) send_byte(frame_buf[i], (i == 0) ? start : 1'b0);
  endtask

  initial begin
    int          pick;
    int          e;
    int          n;
    int unsigned broken_count;
    bit          drained;
    logic [31:0] fee;
    logic [63:0] amount;
    broken_count = 0;
    drained      = 1'b0;
    sb = new();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // clean frame with no start mark after reset, fee and amount at full scale
    build_frame('1, '1);
    send_frame(FRAME_LEN, 1'b0);
    // bytes past the end of a frame are dropped
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    // zero fee and amount, opened with the mark
    build_frame('0, '0);
    send_frame(FRAME_LEN, 1'b1);
    // bad source key type fails on its last byte, then the rest is dropped
    build_frame('1, '0);
    frame_buf[SRC_TYPE_LAST] = 8'h80;
    send_frame(SRC_TYPE_LAST + 4, 1'b1);

    // random frames: mostly well formed, some broken, cut short or plain noise
    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent >= ITEM_TARGET - CALM_TAIL) calm = 1'b1;
      if (!drained && bytes_sent >= ITEM_TARGET / 2) begin
        // hold the sender until the block has delivered everything
        drained = 1'b1;
        s_valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
      end
      pick   = $urandom_range(0, 9);
      fee    = ($urandom_range(0, 7) == 0) ? '1 : 32'($urandom);
      amount = ($urandom_range(0, 7) == 0) ? '0 : {32'($urandom), 32'($urandom)};
      build_frame(fee, amount);
      if (pick < 5) begin
        send_frame(FRAME_LEN, 1'b1);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end else if (pick < 8) begin
        e = break_check_word(broken_count);
        broken_count++;
        n = e + 1 + $urandom_range(0, 12);
        if (n > FRAME_LEN) n = FRAME_LEN;
        send_frame(n, 1'b1);
      end else if (pick == 8) begin
        send_frame($urandom_range(1, FRAME_LEN - 1), 1'b1);
      end else begin
        repeat ($urandom_range(1, 16))
          send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      end
    end

    // let the pipeline empty out
    s_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("fixed_layout_payment_tx_parser_top regression: pass");
    else
      $display("fixed_layout_payment_tx_parser_top regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/fltp_pkg.sv
hdl/fltp_in_reg.sv
hdl/fltp_parse_core.sv
hdl/fltp_out_reg.sv
hdl/fixed_layout_payment_tx_parser_top.sv
test/fixed_layout_payment_tx_parser_top_tb.sv
